/* rtl/core/rgb_frame_resizer_unit_defines.svh */
`ifndef RGB_FRAME_RESIZER_UNIT_DEFINES_SVH
`define RGB_FRAME_RESIZER_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge, outside of reset.
`define RFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rgb_frame_resizer_unit check failed");

// Checks a property on every rising clock edge, including reset cycles.
`define RFR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rgb_frame_resizer_unit check failed");

`endif

/* rtl/core/rfr_pkg.sv */
`default_nettype none
package rfr_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int SIZE_W  = 9;
  localparam int TSIZE_W = 13;
  localparam int POS_W   = 24;
  localparam int CNT_W   = 12;
  localparam int DIV_W   = 25;
  localparam int PIX_W   = 24;
  localparam int WGT_W   = 33;
  localparam int ACC_W   = 41;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TGT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TGT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_KIND       = 3'd4;

  localparam logic [1:0] NB_TL = 2'd0;
  localparam logic [1:0] NB_TR = 2'd1;
  localparam logic [1:0] NB_BL = 2'd2;
  localparam logic [1:0] NB_BR = 2'd3;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_sel_y;
    logic       take_x;
    logic       take_y;
    logic       issue;
    logic [1:0] nb;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic pass_start;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/rfr_divider.sv */
`default_nettype none
module rfr_divider
  import rfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_W-1:0]   num,
  input  wire logic [TSIZE_W-1:0] den,
  output logic                    done,
  output logic [POS_W-1:0]        quo
);

  logic               busy;
  logic [4:0]         cnt;
  logic [DIV_W-1:0]   numsh;
  logic [TSIZE_W-1:0] rem;
  logic [DIV_W-1:0]   q;
  logic [TSIZE_W:0]   trial;

  assign trial = {rem, numsh[DIV_W-1]};
  assign quo   = q[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      numsh <= num;
      rem   <= '0;
      q     <= '0;
    end else if (busy) begin
      numsh <= {numsh[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= TSIZE_W'(trial - {1'b0, den});
        q   <= {q[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[TSIZE_W-1:0];
        q   <= {q[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rfr_datapath.sv */
`default_nettype none
module rfr_datapath
  import rfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic [PIX_W-1:0]   pixel_in,
  input  wire logic [SIZE_W-1:0]  source_width,
  input  wire logic [SIZE_W-1:0]  source_height,
  input  wire logic [TSIZE_W-1:0] target_width,
  input  wire logic [TSIZE_W-1:0] target_height,
  input  wire logic               resize_kind,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PIX_W-1:0]        out_pixel,
  output logic                    out_last
);

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(STORE);
  localparam int BW    = 2 * SIZE_W + 1;

  logic [PIX_W-1:0] mem [STORE];

  logic [AW-1:0]      ptr;
  logic [POS_W-1:0]   xpos, ypos, xstep, ystep;
  logic [CNT_W-1:0]   col, row;
  logic [WGT_W-1:0]   w_q;
  logic [PIX_W-1:0]   rd_q;
  logic               v1, v2;
  logic [ACC_W-1:0]   prod_r, prod_g, prod_b;
  logic [ACC_W-1:0]   acc_r, acc_g, acc_b;

  logic [SIZE_W-1:0]  sw_e, sh_e, xlim, ylim, xr, yr;
  logic [TSIZE_W-1:0] tw_e, th_e;
  logic [BW-1:0]      base, addr;
  logic [16:0]        dx, dy, ndx, ndy, wa, wb;
  logic [WGT_W-1:0]   wgt;
  logic               row_end, frame_end;
  logic [POS_W-1:0]   quo, row_start_x;
  logic               div_done;
  logic [DIV_W-1:0]   div_num;
  logic [TSIZE_W-1:0] div_den;

  always_comb begin
    if (source_width < SIZE_W'(2))                sw_e = SIZE_W'(2);
    else if (32'(source_width) > MAX_WIDTH)       sw_e = SIZE_W'(MAX_WIDTH);
    else                                          sw_e = source_width;
    if (source_height < SIZE_W'(2))               sh_e = SIZE_W'(2);
    else if (32'(source_height) > MAX_HEIGHT)     sh_e = SIZE_W'(MAX_HEIGHT);
    else                                          sh_e = source_height;
    if (target_width == '0)                       tw_e = TSIZE_W'(1);
    else if (target_width > TSIZE_W'(4096))       tw_e = TSIZE_W'(4096);
    else                                          tw_e = target_width;
    if (target_height == '0)                      th_e = TSIZE_W'(1);
    else if (target_height > TSIZE_W'(4096))      th_e = TSIZE_W'(4096);
    else                                          th_e = target_height;
  end

  assign div_num = cmd.div_sel_y ? {sh_e - SIZE_W'(1), 16'd0} : {sw_e - SIZE_W'(1), 16'd0};
  assign div_den = cmd.div_sel_y ? th_e : tw_e;

  rfr_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // Neighbour coordinates are held inside the frame so all four reads are valid.
  always_comb begin
    xlim = sw_e - SIZE_W'(2);
    ylim = sh_e - SIZE_W'(2);
    xr   = ({1'b0, xpos[23:16]} > xlim) ? xlim : {1'b0, xpos[23:16]};
    yr   = ({1'b0, ypos[23:16]} > ylim) ? ylim : {1'b0, ypos[23:16]};
    base = BW'(yr * sw_e) + BW'(xr);
    case (cmd.nb)
      NB_TL:   addr = base;
      NB_TR:   addr = base + BW'(1);
      NB_BL:   addr = base + BW'(sw_e);
      default: addr = base + BW'(sw_e) + BW'(1);
    endcase
  end

  always_comb begin
    dx  = {1'b0, xpos[15:0]};
    dy  = {1'b0, ypos[15:0]};
    ndx = 17'h10000 - dx;
    ndy = 17'h10000 - dy;
    case (cmd.nb)
      NB_TL:   begin wa = ndx; wb = ndy; end
      NB_TR:   begin wa = dx;  wb = ndy; end
      NB_BL:   begin wa = ndx; wb = dy;  end
      default: begin wa = dx;  wb = dy;  end
    endcase
    // A weight of a quarter of one makes the blend a plain four-pixel average.
    wgt = resize_kind ? WGT_W'(33'h040000000) : WGT_W'(wa * wb);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mem[ptr] <= pixel_in;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) rd_q <= mem[AW'(addr)];
  end

  always_ff @(posedge clk) begin
    w_q    <= wgt;
    prod_r <= w_q * rd_q[7:0];
    prod_g <= w_q * rd_q[15:8];
    prod_b <= w_q * rd_q[23:16];
    if (cmd.issue && cmd.nb == NB_TL) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (v2) begin
      acc_r <= acc_r + prod_r;
      acc_g <= acc_g + prod_g;
      acc_b <= acc_b + prod_b;
    end
  end

  assign row_end     = (TSIZE_W'(col) + TSIZE_W'(1)) >= tw_e;
  assign frame_end   = row_end && ((TSIZE_W'(row) + TSIZE_W'(1)) >= th_e);
  assign row_start_x = resize_kind ? (xstep >> 1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      xpos  <= '0;
      ypos  <= '0;
      xstep <= '0;
      ystep <= '0;
      col   <= '0;
      row   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.load) begin
        if ((32'(ptr) + 1) >= (32'(sw_e) * 32'(sh_e))) ptr <= '0;
        else                                          ptr <= ptr + AW'(1);
      end
      if (cmd.take_x) xstep <= quo;
      if (cmd.take_y) begin
        ystep <= quo;
        xpos  <= row_start_x;
        ypos  <= resize_kind ? (quo >> 1) : '0;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (frame_end) begin
          col  <= '0;
          row  <= '0;
          xpos <= '0;
          ypos <= '0;
        end else if (row_end) begin
          col  <= '0;
          row  <= row + CNT_W'(1);
          ypos <= ypos + ystep;
          xpos <= row_start_x;
        end else begin
          col  <= col + CNT_W'(1);
          xpos <= xpos + xstep;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pixel <= {acc_b[39:32], acc_g[39:32], acc_r[39:32]};
      out_last  <= frame_end;
    end
  end

  assign status.pass_start = (col == '0) && (row == '0);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

/* rtl/core/rfr_ctrl.sv */
`default_nettype none
module rfr_ctrl
  import rfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_emit,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIVX  = 3'd1;
  localparam logic [2:0] ST_WAITX = 3'd2;
  localparam logic [2:0] ST_DIVY  = 3'd3;
  localparam logic [2:0] ST_WAITY = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] cnt, cnt_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_emit) begin
            cmd.load = 1'b1;
          end else begin
            cnt_next   = '0;
            state_next = status.pass_start ? ST_DIVX : ST_READ;
          end
        end
      end
      ST_DIVX: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAITX;
      end
      ST_WAITX: begin
        if (status.div_done) begin
          cmd.take_x = 1'b1;
          state_next = ST_DIVY;
        end
      end
      ST_DIVY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_next    = ST_WAITY;
      end
      ST_WAITY: begin
        cmd.div_sel_y = 1'b1;
        if (status.div_done) begin
          cmd.take_y = 1'b1;
          cnt_next   = '0;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.issue = 1'b1;
        cmd.nb    = cnt;
        cnt_next  = cnt + 2'd1;
        if (cnt == NB_BR) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The drain state lets the last products reach the accumulators.
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd1) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rgb_frame_resizer_unit.sv */
`default_nettype none
// Bilinear / four-pixel-average RGB frame resizer. A transfer with tuser low
// stores one source pixel in raster order and leaves the block ready for the
// next transfer; a transfer with tuser high produces the next pixel of the
// resized frame, and tlast marks the final pixel of that frame. The next
// transfer is taken only once that pixel is registered: the four neighbours
// are read one per cycle from the single-port frame store and pass through a
// two-stage multiply-accumulate, then a drain state and a state that registers
// the result. A result that waits at the output holds the block until it is
// taken. The first pixel of each pass also waits while a shared bit-serial
// divider works out the horizontal and vertical steps, one quotient bit per
// cycle. The user must set sizes and mode through the register port only
// while no pixel is in flight; the block itself does not enforce this.
module rgb_frame_resizer_unit
  import rfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
  input  wire logic        s_tuser,   // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // red_out, green_out, blue_out
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SIZE_W-1:0]  source_width, source_height;
  logic [TSIZE_W-1:0] target_width, target_height;
  logic               resize_kind;
  logic [2:0]         reg_idx;
  cmd_t               cmd;
  status_t            status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIZE_W'(256);
      source_height <= SIZE_W'(256);
      target_width  <= TSIZE_W'(256);
      target_height <= TSIZE_W'(256);
      resize_kind   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  source_width  <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: source_height <= pwdata[SIZE_W-1:0];
        REG_TGT_WIDTH:  target_width  <= pwdata[TSIZE_W-1:0];
        REG_TGT_HEIGHT: target_height <= pwdata[TSIZE_W-1:0];
        REG_KIND:       resize_kind   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = 32'(source_width);
      REG_SRC_HEIGHT: prdata = 32'(source_height);
      REG_TGT_WIDTH:  prdata = 32'(target_width);
      REG_TGT_HEIGHT: prdata = 32'(target_height);
      REG_KIND:       prdata = 32'(resize_kind);
      default:        prdata = '0;
    endcase
  end

  rfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_emit  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rfr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .pixel_in      (s_tdata),
    .source_width  (source_width),
    .source_height (source_height),
    .target_width  (target_width),
    .target_height (target_height),
    .resize_kind   (resize_kind),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_pixel     (m_tdata),
    .out_last      (m_tlast)
  );

endmodule
`default_nettype wire

/* rtl/core/rfr_checker.sv */
`default_nettype none
`include "rgb_frame_resizer_unit_defines.svh"
module rfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast
);

  // No result may be pending right after reset.
  `RFR_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid)

  // A stalled result keeps its pixel and its frame mark.
  `RFR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Storing a source pixel never makes a result appear.
  `RFR_ASSERT(a_load_silent, s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)

  // Producing a pixel leaves the block not ready in the cycle after the transfer.
  `RFR_ASSERT(a_emit_busy, s_tvalid && s_tready && s_tuser |=> !s_tready)

endmodule

bind rgb_frame_resizer_unit rfr_checker u_rfr_checker (.*);
`default_nettype wire

/* tb/rgb_frame_resizer_unit_tb.sv */
`default_nettype none

class resize_scoreboard;
  localparam int STORE_DEPTH = 65536;

  bit [23:0] frame_store[STORE_DEPTH];
  bit        written[STORE_DEPTH];
  int unsigned load_ptr;
  bit [23:0] x_pos, y_pos, x_inc, y_inc;
  int unsigned col, row;
  int unsigned src_w, src_h, dst_w, dst_h;
  bit          avg_kind;

  typedef struct {
    bit [23:0] rgb;
    bit        last;
  } pixel_t;
  pixel_t expected_pixels[$];

  int mismatches;
  int pixels_checked;
  int loads_seen;
  int frames_seen;

  function new();
    load_ptr = 0; x_pos = 0; y_pos = 0; x_inc = 0; y_inc = 0; col = 0; row = 0;
    src_w = 256; src_h = 256; dst_w = 256; dst_h = 256; avg_kind = 0;
  endfunction

  function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function int unsigned eff_sw();
    return clip(src_w, 2, rfr_pkg::MAX_WIDTH);
  endfunction

  function int unsigned eff_sh();
    return clip(src_h, 2, rfr_pkg::MAX_HEIGHT);
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      rfr_pkg::REG_SRC_WIDTH:  src_w = v[8:0];
      rfr_pkg::REG_SRC_HEIGHT: src_h = v[8:0];
      rfr_pkg::REG_TGT_WIDTH:  dst_w = v[12:0];
      rfr_pkg::REG_TGT_HEIGHT: dst_h = v[12:0];
      rfr_pkg::REG_KIND:       avg_kind = v[0];
      default: ;
    endcase
  endfunction

  function bit frame_ready();
    int unsigned n;
    n = eff_sw() * eff_sh();
    for (int unsigned i = 0; i < n; i++)
      if (!written[i]) return 0;
    return 1;
  endfunction

  function void note_input(bit emit, bit [23:0] data);
    int unsigned sw, sh, tw, th, xr, yr, base;
    bit [23:0] tl, tr, bl, br;
    bit [63:0] dx, dy, ndx, ndy, acc;
    bit [9:0]  total;
    pixel_t p;
    bit row_end, frame_end;
    sw = eff_sw(); sh = eff_sh();
    tw = clip(dst_w, 1, 4096); th = clip(dst_h, 1, 4096);
    if (!emit) begin
      frame_store[load_ptr] = data;
      written[load_ptr] = 1;
      loads_seen++;
      if (load_ptr + 1 >= sw * sh) load_ptr = 0;
      else load_ptr = (load_ptr + 1) & 16'hffff;
      return;
    end
    if (col == 0 && row == 0) begin
      x_inc = ((sw - 1) << 16) / tw;
      y_inc = ((sh - 1) << 16) / th;
      x_pos = avg_kind ? x_inc >> 1 : 24'd0;
      y_pos = avg_kind ? y_inc >> 1 : 24'd0;
    end
    xr = x_pos >> 16; yr = y_pos >> 16;
    if (xr > sw - 2) xr = sw - 2;
    if (yr > sh - 2) yr = sh - 2;
    base = yr * sw + xr;
    tl = frame_store[base];      tr = frame_store[base + 1];
    bl = frame_store[base + sw]; br = frame_store[base + sw + 1];
    dx = x_pos[15:0]; dy = y_pos[15:0];
    ndx = 65536 - dx; ndy = 65536 - dy;
    for (int c = 0; c < 3; c++) begin
      if (avg_kind) begin
        total = tl[8*c +: 8] + tr[8*c +: 8] + bl[8*c +: 8] + br[8*c +: 8];
        p.rgb[8*c +: 8] = total >> 2;
      end else begin
        acc = ndx * ndy * tl[8*c +: 8] + dx * ndy * tr[8*c +: 8]
            + ndx * dy * bl[8*c +: 8] + dx * dy * br[8*c +: 8];
        p.rgb[8*c +: 8] = acc[39:32];
      end
    end
    row_end = col + 1 >= tw;
    frame_end = row_end && (row + 1 >= th);
    p.last = frame_end;
    expected_pixels.push_back(p);
    if (frame_end) begin
      col = 0; row = 0; x_pos = 0; y_pos = 0;
    end else if (row_end) begin
      col = 0;
      row = (row + 1) & 12'hfff;
      y_pos = y_pos + y_inc;
      x_pos = avg_kind ? x_inc >> 1 : 24'd0;
    end else begin
      col = (col + 1) & 12'hfff;
      x_pos = x_pos + x_inc;
    end
  endfunction

  task report(string what, int got, int want);
    $display("mismatch on pixel %0d: %s got %0d expected %0d",
             pixels_checked, what, got, want);
    mismatches++;
  endtask

  task check_result(bit [23:0] rgb, bit last);
    pixel_t p;
    if (expected_pixels.size() == 0) begin
      report("unexpected pixel", int'(rgb), 0);
      return;
    end
    p = expected_pixels.pop_front();
    if (rgb[7:0] != p.rgb[7:0]) report("red", rgb[7:0], p.rgb[7:0]);
    if (rgb[15:8] != p.rgb[15:8]) report("green", rgb[15:8], p.rgb[15:8]);
    if (rgb[23:16] != p.rgb[23:16]) report("blue", rgb[23:16], p.rgb[23:16]);
    if (last != p.last) report("frame_last", last, p.last);
    if (last) frames_seen++;
    pixels_checked++;
  endtask
endclass

module rgb_frame_resizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfr_pkg::*;

  localparam bit MODE_LOAD = 1'b0;
  localparam bit MODE_EMIT = 1'b1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 450;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = 0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  resize_scoreboard sb = new();
  int send_idle_pct = 26;
  int recv_idle_pct = 56;
  int cycles = 0;
  int random_items = 0;

  rgb_frame_resizer_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb_frame_resizer_unit_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  task automatic send(bit emit, logic [23:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= emit;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    sb.note_input(emit, data);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return $urandom();
    endcase
  endfunction

  // Sizes may only change once the block has drained every pixel in flight.
  task automatic configure(int sw, int sh, int tw, int th, bit kind);
    s_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_TGT_WIDTH, tw);
    write_reg(REG_TGT_HEIGHT, th);
    write_reg(REG_KIND, kind);
    while (!sb.frame_ready()) send(MODE_LOAD, rand_pixel());
  endtask

  task automatic run_pixels(int n, int load_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < load_pct) send(MODE_LOAD, rand_pixel());
      else send(MODE_EMIT, $urandom());
      random_items++;
    end
  endtask

  initial begin
    int sw, sh, tw, th;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(2, 2, 1, 1, 0);
    run_pixels(3, 0);
    configure(2, 2, 3, 2, 1);
    run_pixels(6, 0);
    // Out-of-range sizes saturate into the usable range.
    configure(0, 1, 0, 0, 0);
    run_pixels(2, 0);
    configure(2, 2, 4096, 1, 0);
    run_pixels(40, 0);
    configure(2, 3, 1, 8191, 1);
    run_pixels(40, 0);
    configure(5, 4, 7, 3, 0);
    run_pixels(25, 10);
    random_items = 0;

    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (random_items >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 56; recv_idle_pct = 26;
      end
      sw = $urandom_range(2, 12);
      sh = $urandom_range(2, 12);
      tw = $urandom_range(1, 24);
      th = $urandom_range(1, 24);
      if ($urandom_range(9) == 0) sw = $urandom_range(0, 1);
      if ($urandom_range(9) == 0) th = 0;
      if ($urandom_range(19) == 0) tw = $urandom_range(4097, 8191);
      configure(sw, sh, tw, th, $urandom_range(1));
      run_pixels($urandom_range(10, 60), 20);
    end

    s_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d resized pixels over %0d frames after %0d source loads,",
             sb.pixels_checked, sb.frames_seen, sb.loads_seen);
    $display("covering both resize kinds, saturated sizes and mid-frame resizing.");
    if (sb.mismatches == 0) begin
      $display("rgb_frame_resizer_unit_tb passed");
    end else begin
      $display("rgb_frame_resizer_unit_tb failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/rfr_pkg.sv
rtl/core/rfr_divider.sv
rtl/core/rfr_datapath.sv
rtl/core/rfr_ctrl.sv
rtl/core/rgb_frame_resizer_unit.sv
rtl/core/rfr_checker.sv
tb/rgb_frame_resizer_unit_tb.sv
